FILE: src/tsp_pkg.sv
package tsp_pkg;

  localparam int unsigned LineMaxDefault = 4096;

  localparam logic [2:0] PH_TEXT   = 3'd0;
  localparam logic [2:0] PH_IAC    = 3'd1;
  localparam logic [2:0] PH_VERB   = 3'd2;
  localparam logic [2:0] PH_SBOPT  = 3'd3;
  localparam logic [2:0] PH_SUB    = 3'd4;
  localparam logic [2:0] PH_SUBIAC = 3'd5;
  localparam logic [2:0] PH_CR     = 3'd6;

  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_NAWS = 8'h1F;
  localparam logic [7:0] B_DEL  = 8'h7F;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_SP   = 8'h20;

  localparam logic [0:0] REG_CANON = 1'd0;
  localparam logic [0:0] REG_MASK  = 1'd1;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_LINE   = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_TX     = 3'd3,
    KIND_WIN    = 3'd4,
    KIND_SUBB   = 3'd5,
    KIND_SUBEND = 3'd6
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [7:0]  option_code;
    logic [15:0] win_width;
    logic [15:0] win_height;
  } res_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic [2:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
    res_t       r3;
  } job_t;

  function automatic res_t mk(logic [2:0] k, logic [7:0] v, logic [7:0] o,
                              logic [15:0] w, logic [15:0] h);
    res_t r;
    r.kind = k;
    r.value = v;
    r.option_code = o;
    r.win_width = w;
    r.win_height = h;
    return r;
  endfunction

endpackage

FILE: src/tsp_if.sv
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [7:0]  option_code;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic        last;
  modport source (output valid, kind, value, option_code, win_width, win_height, last,
                  input ready);
  modport sink (input valid, kind, value, option_code, win_width, win_height, last,
                output ready);
endinterface

interface tsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tsp_front.sv
module tsp_front #(
  parameter int unsigned LineMax = tsp_pkg::LineMaxDefault,
  localparam int unsigned LenW = $clog2(LineMax + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             canon_i,
  input  logic [3:0]       mask_i,
  input  logic             fire_i,
  input  logic [7:0]       b_i,
  output tsp_pkg::job_t    job_o
);
  logic [2:0]  ph_q, ph_d;
  logic [1:0]  verb_q, verb_d;
  logic [7:0]  sopt_q, sopt_d;
  logic [2:0]  scnt_q, scnt_d;
  logic [31:0] win_q, win_d;
  logic [LenW-1:0] len_q, len_d;
  logic [3:0]  loc_q, loc_d, rem_q, rem_d;

  tsp_pkg::res_t rs [4];
  logic [2:0] n;

  always_comb begin
    logic [3:0] bit_v;
    logic [7:0] sb;
    logic       do_sub;
    ph_d = ph_q; verb_d = verb_q; sopt_d = sopt_q; scnt_d = scnt_q;
    win_d = win_q; len_d = len_q; loc_d = loc_q; rem_d = rem_q;
    n = 3'd0;
    for (int i = 0; i < 4; i++) rs[i] = '0;
    do_sub = 1'b0;
    sb = b_i;
    unique case (b_i)
      8'h00:   bit_v = 4'b0001;
      8'h01:   bit_v = 4'b0010;
      tsp_pkg::B_NAWS: bit_v = 4'b0100;
      8'h03:   bit_v = 4'b1000;
      default: bit_v = 4'b0000;
    endcase
    unique case (ph_q)
      tsp_pkg::PH_IAC: begin
        ph_d = tsp_pkg::PH_TEXT;
        if (b_i >= tsp_pkg::B_WILL && b_i <= tsp_pkg::B_DONT) begin
          verb_d = 2'(b_i - tsp_pkg::B_WILL);
          ph_d = tsp_pkg::PH_VERB;
        end else if (b_i == tsp_pkg::B_SB) begin
          ph_d = tsp_pkg::PH_SBOPT;
        end else if (b_i == tsp_pkg::B_IAC) begin
          if (canon_i && len_q < LenW'(LineMax)) len_d = len_q + 1'b1;
          rs[0] = tsp_pkg::mk(tsp_pkg::KIND_DATA, tsp_pkg::B_IAC, '0, '0, '0);
          n = 3'd1;
        end
      end
      tsp_pkg::PH_VERB: begin
        ph_d = tsp_pkg::PH_TEXT;
        rs[0] = tsp_pkg::mk(tsp_pkg::KIND_TX, tsp_pkg::B_IAC, '0, '0, '0);
        rs[2] = tsp_pkg::mk(tsp_pkg::KIND_TX, b_i, '0, '0, '0);
        rs[1] = tsp_pkg::mk(tsp_pkg::KIND_TX, tsp_pkg::B_WONT, '0, '0, '0);
        n = 3'd3;
        case (verb_q)
          2'd0: begin
            rem_d = rem_q | bit_v;
            rs[1].value = (bit_v != 0) ? tsp_pkg::B_DO : tsp_pkg::B_DONT;
          end
          2'd1: begin
            rem_d = rem_q & ~bit_v;
            rs[1].value = tsp_pkg::B_DONT;
          end
          2'd2: begin
            if ((bit_v & mask_i) != 0) begin
              loc_d = loc_q | bit_v;
              rs[1].value = tsp_pkg::B_WILL;
            end
          end
          default: loc_d = loc_q & ~bit_v;
        endcase
      end
      tsp_pkg::PH_SBOPT: begin
        sopt_d = b_i; scnt_d = '0; win_d = '0; ph_d = tsp_pkg::PH_SUB;
      end
      tsp_pkg::PH_SUB: begin
        if (b_i == tsp_pkg::B_IAC) ph_d = tsp_pkg::PH_SUBIAC;
        else do_sub = 1'b1;
      end
      tsp_pkg::PH_SUBIAC: begin
        ph_d = tsp_pkg::PH_SUB;
        if (b_i == tsp_pkg::B_SE) begin
          if (sopt_q == tsp_pkg::B_NAWS)
            rs[0] = tsp_pkg::mk(tsp_pkg::KIND_WIN, '0, '0, win_q[31:16], win_q[15:0]);
          else
            rs[0] = tsp_pkg::mk(tsp_pkg::KIND_SUBEND, '0, sopt_q, '0, '0);
          n = 3'd1;
          scnt_d = '0; win_d = '0; ph_d = tsp_pkg::PH_TEXT;
        end else if (b_i == tsp_pkg::B_IAC) begin
          do_sub = 1'b1;
        end
      end
      tsp_pkg::PH_CR: begin
        ph_d = tsp_pkg::PH_TEXT;
        if (b_i == 8'h00 || b_i == tsp_pkg::B_LF) begin
          len_d = '0;
          rs[0] = tsp_pkg::mk(tsp_pkg::KIND_LINE, '0, '0, '0, '0);
          n = 3'd1;
        end
      end
      default: begin
        ph_d = tsp_pkg::PH_TEXT;
        if (b_i == tsp_pkg::B_IAC) begin
          ph_d = tsp_pkg::PH_IAC;
        end else if (b_i == tsp_pkg::B_SB) begin
          ph_d = tsp_pkg::PH_TEXT;
        end else if (canon_i && (b_i < tsp_pkg::B_SP || b_i >= tsp_pkg::B_DEL)) begin
          if (b_i == tsp_pkg::B_CR) begin
            ph_d = tsp_pkg::PH_CR;
          end else if (b_i == tsp_pkg::B_DEL && len_q != '0) begin
            len_d = len_q - 1'b1;
            rs[0] = tsp_pkg::mk(tsp_pkg::KIND_ERASE, '0, '0, '0, '0);
            rs[1] = tsp_pkg::mk(tsp_pkg::KIND_TX, tsp_pkg::B_BS, '0, '0, '0);
            rs[2] = tsp_pkg::mk(tsp_pkg::KIND_TX, tsp_pkg::B_SP, '0, '0, '0);
            rs[3] = tsp_pkg::mk(tsp_pkg::KIND_TX, tsp_pkg::B_BS, '0, '0, '0);
            n = 3'd4;
          end
        end else begin
          if (canon_i && len_q < LenW'(LineMax)) len_d = len_q + 1'b1;
          rs[0] = tsp_pkg::mk(tsp_pkg::KIND_DATA, b_i, '0, '0, '0);
          rs[1] = tsp_pkg::mk(tsp_pkg::KIND_TX, b_i, '0, '0, '0);
          n = loc_q[1] ? 3'd2 : 3'd1;
        end
      end
    endcase
    if (do_sub) begin
      if (sopt_q == tsp_pkg::B_NAWS) begin
        if (scnt_q < 3'd4) begin
          unique case (scnt_q[1:0])
            2'd0: win_d[31:24] = sb;
            2'd1: win_d[23:16] = sb;
            2'd2: win_d[15:8]  = sb;
            default: win_d[7:0] = sb;
          endcase
          scnt_d = scnt_q + 1'b1;
        end
      end else begin
        rs[0] = tsp_pkg::mk(tsp_pkg::KIND_SUBB, sb, sopt_q, '0, '0);
        n = 3'd1;
      end
    end
  end

  assign job_o = '{n: n, r0: rs[0], r1: rs[1], r2: rs[2], r3: rs[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= tsp_pkg::PH_TEXT; verb_q <= '0; sopt_q <= '0; scnt_q <= '0;
      win_q <= '0; len_q <= '0; loc_q <= '0; rem_q <= '0;
    end else if (fire_i) begin
      ph_q <= ph_d; verb_q <= verb_d; sopt_q <= sopt_d; scnt_q <= scnt_d;
      win_q <= win_d; len_q <= len_d; loc_q <= loc_d; rem_q <= rem_d;
    end
  end
endmodule

FILE: src/tsp_back.sv
module tsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsp_pkg::job_t  job_i,
  output logic           full_o,
  tsp_out_if.source      out
);
  // two-entry job queue, then result sequencer
  tsp_pkg::job_t q_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic [1:0]    idx_q;
  tsp_pkg::job_t hd;
  tsp_pkg::res_t r;
  logic          busy;
  logic          pop, take;

  assign hd = q_q[rp_q];
  assign full_o = (cnt_q == 2'd2);
  assign busy = (cnt_q != 2'd0);
  assign out.valid = busy;
  assign take = out.valid && out.ready;
  assign pop = take && ({1'b0, idx_q} + 3'd1 == hd.n);

  always_comb begin
    case (idx_q)
      2'd0: r = hd.r0;
      2'd1: r = hd.r1;
      2'd2: r = hd.r2;
      default: r = hd.r3;
    endcase
  end
  assign out.kind = r.kind;
  assign out.value = r.value;
  assign out.option_code = r.option_code;
  assign out.win_width = r.win_width;
  assign out.win_height = r.win_height;
  assign out.last = ({1'b0, idx_q} + 3'd1 == hd.n);

  always_ff @(posedge clk_i) begin
    if (push_i) q_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) begin
        rp_q <= ~rp_q;
        idx_q <= '0;
      end else if (take) begin
        idx_q <= idx_q + 1'b1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end
endmodule

FILE: src/telnet_stream_parser.sv
// Telnet receive parser: front end classifies bytes, back end sequences results.
// Each accepted byte's job is registered in the back-end job queue before its results reach the output.
// Throughput: one input byte per cycle while the job queue is not full; one result per
// cycle while the result port is ready. A byte yields 0 to 4 results.
// Reset: asynchronous, active low; text phase, flags cleared, canonical mode, mask 4'hF.
module telnet_stream_parser #(
  parameter int unsigned LineMax = tsp_pkg::LineMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsp_in_if.sink     in,
  tsp_cfg_if.sink    cfg,
  tsp_out_if.source  out
);
  logic          canon_q;
  logic [3:0]    mask_q;
  tsp_pkg::job_t job;
  logic          full, fire, push;

  assign cfg.ready = 1'b1;
  assign in.ready = !full;
  assign fire = in.valid && in.ready;
  assign push = fire && (job.n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q <= 1'b1;
      mask_q  <= 4'hF;
    end else if (cfg.valid) begin
      case (cfg.index)
        tsp_pkg::REG_CANON: canon_q <= cfg.data[0];
        default:            mask_q  <= cfg.data[3:0];
      endcase
    end
  end

  tsp_front #(.LineMax(LineMax)) u_front (
    .clk_i, .rst_ni, .canon_i(canon_q), .mask_i(mask_q),
    .fire_i(fire), .b_i(in.rx_byte), .job_o(job)
  );

  tsp_back u_back (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .full_o(full), .out(out)
  );
endmodule

FILE: src/tsp_checker.sv
module tsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last,
  input logic       in_ready
);
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_kind != 3'd7) else $error("bad kind");
  a_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == tsp_pkg::KIND_ERASE |-> !out_last) else $error("erase last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("hold");
  a_erase_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_kind == tsp_pkg::KIND_ERASE |=>
    out_valid && out_kind == tsp_pkg::KIND_TX)
    else $error("erase seq");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid) else $error("stall without results");
endmodule

bind telnet_stream_parser tsp_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out.valid), .out_ready(out.ready), .out_kind(out.kind),
  .out_value(out.value), .out_last(out.last), .in_ready(in.ready)
);

FILE: test/telnet_stream_parser_tb.sv
`timescale 1ns / 1ps

class tsp_scoreboard;
  tsp_pkg::res_t exp_q[$];
  bit            exp_last_q[$];
  int            errors;
  int            checked;
  bit            canon;
  logic [3:0]    enable_mask;
  logic [2:0]    phase;
  logic [1:0]    verb;
  logic [7:0]    sub_opt;
  logic [2:0]    sub_cnt;
  logic [31:0]   win_cap;
  logic [12:0]   line_len;
  logic [3:0]    local_on;
  logic [3:0]    remote_on;
  tsp_pkg::res_t batch[$];

  function new();
    canon = 1'b1;
    enable_mask = 4'hF;
    phase = tsp_pkg::PH_TEXT;
    verb = '0;
    sub_opt = '0;
    sub_cnt = '0;
    win_cap = '0;
    line_len = '0;
    local_on = '0;
    remote_on = '0;
    errors = 0;
    checked = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [7:0] data);
    if (idx == tsp_pkg::REG_CANON) canon = data[0];
    else enable_mask = data[3:0];
  endfunction

  function void push(logic [2:0] k, logic [7:0] v, logic [7:0] o,
                     logic [15:0] w, logic [15:0] h);
    tsp_pkg::res_t r;
    r.kind = k;
    r.value = v;
    r.option_code = o;
    r.win_width = w;
    r.win_height = h;
    if (batch.size() < 4) batch.push_back(r);
  endfunction

  function void send_reply(logic [7:0] vb, logic [7:0] opt);
    push(tsp_pkg::KIND_TX, tsp_pkg::B_IAC, 0, 0, 0);
    push(tsp_pkg::KIND_TX, vb, 0, 0, 0);
    push(tsp_pkg::KIND_TX, opt, 0, 0, 0);
  endfunction

  function void bump_line();
    if (line_len < 13'd4096) line_len++;
  endfunction

  function void sub_data(logic [7:0] b);
    if (sub_opt == tsp_pkg::B_NAWS) begin
      if (sub_cnt < 3'd4) begin
        win_cap = win_cap | (32'(b) << (24 - 8 * sub_cnt));
        sub_cnt++;
      end
    end else begin
      push(tsp_pkg::KIND_SUBB, b, sub_opt, 0, 0);
    end
  endfunction

  function void negotiate(logic [7:0] opt);
    logic [3:0] bit_sel;
    case (opt)
      8'h00: bit_sel = 4'b0001;
      8'h01: bit_sel = 4'b0010;
      tsp_pkg::B_NAWS: bit_sel = 4'b0100;
      8'h03: bit_sel = 4'b1000;
      default: bit_sel = 4'b0000;
    endcase
    case (verb)
      2'd0: begin
        if (bit_sel != 0) begin
          remote_on |= bit_sel;
          send_reply(tsp_pkg::B_DO, opt);
        end else begin
          send_reply(tsp_pkg::B_DONT, opt);
        end
      end
      2'd1: begin
        remote_on &= ~bit_sel;
        send_reply(tsp_pkg::B_DONT, opt);
      end
      2'd2: begin
        if ((bit_sel & enable_mask) != 0) begin
          local_on |= bit_sel;
          send_reply(tsp_pkg::B_WILL, opt);
        end else begin
          send_reply(tsp_pkg::B_WONT, opt);
        end
      end
      default: begin
        local_on &= ~bit_sel;
        send_reply(tsp_pkg::B_WONT, opt);
      end
    endcase
  endfunction

  function void text(logic [7:0] b);
    bit echo;
    echo = local_on[1];
    if (b == tsp_pkg::B_IAC) begin
      phase = tsp_pkg::PH_IAC;
      return;
    end
    if (b == tsp_pkg::B_SB) return;
    if (canon) begin
      if (b < 8'h20 || b >= tsp_pkg::B_DEL) begin
        if (b == tsp_pkg::B_CR) begin
          phase = tsp_pkg::PH_CR;
        end else if (b == tsp_pkg::B_DEL && line_len > 0) begin
          line_len--;
          push(tsp_pkg::KIND_ERASE, 0, 0, 0, 0);
          push(tsp_pkg::KIND_TX, tsp_pkg::B_BS, 0, 0, 0);
          push(tsp_pkg::KIND_TX, tsp_pkg::B_SP, 0, 0, 0);
          push(tsp_pkg::KIND_TX, tsp_pkg::B_BS, 0, 0, 0);
        end
        return;
      end
      bump_line();
    end
    push(tsp_pkg::KIND_DATA, b, 0, 0, 0);
    if (echo) push(tsp_pkg::KIND_TX, b, 0, 0, 0);
  endfunction

  // note one accepted input byte and queue what it should produce
  function void note_byte(logic [7:0] b);
    batch.delete();
    case (phase)
      tsp_pkg::PH_IAC: begin
        phase = tsp_pkg::PH_TEXT;
        if (b >= tsp_pkg::B_WILL && b <= tsp_pkg::B_DONT) begin
          verb = 2'(b - tsp_pkg::B_WILL);
          phase = tsp_pkg::PH_VERB;
        end else if (b == tsp_pkg::B_SB) begin
          phase = tsp_pkg::PH_SBOPT;
        end else if (b == tsp_pkg::B_IAC) begin
          if (canon) bump_line();
          push(tsp_pkg::KIND_DATA, tsp_pkg::B_IAC, 0, 0, 0);
        end
      end
      tsp_pkg::PH_VERB: begin
        phase = tsp_pkg::PH_TEXT;
        negotiate(b);
      end
      tsp_pkg::PH_SBOPT: begin
        sub_opt = b;
        sub_cnt = 0;
        win_cap = 0;
        phase = tsp_pkg::PH_SUB;
      end
      tsp_pkg::PH_SUB: begin
        if (b == tsp_pkg::B_IAC) phase = tsp_pkg::PH_SUBIAC;
        else sub_data(b);
      end
      tsp_pkg::PH_SUBIAC: begin
        phase = tsp_pkg::PH_SUB;
        if (b == tsp_pkg::B_SE) begin
          if (sub_opt == tsp_pkg::B_NAWS)
            push(tsp_pkg::KIND_WIN, 0, 0, win_cap[31:16], win_cap[15:0]);
          else
            push(tsp_pkg::KIND_SUBEND, 0, sub_opt, 0, 0);
          sub_cnt = 0;
          win_cap = 0;
          phase = tsp_pkg::PH_TEXT;
        end else if (b == tsp_pkg::B_IAC) begin
          sub_data(tsp_pkg::B_IAC);
        end
      end
      tsp_pkg::PH_CR: begin
        phase = tsp_pkg::PH_TEXT;
        if (b == 8'h00 || b == tsp_pkg::B_LF) begin
          line_len = 0;
          push(tsp_pkg::KIND_LINE, 0, 0, 0, 0);
        end
      end
      default: begin
        phase = tsp_pkg::PH_TEXT;
        text(b);
      end
    endcase
    foreach (batch[i]) begin
      exp_q.push_back(batch[i]);
      exp_last_q.push_back(i == batch.size() - 1);
    end
  endfunction

  function void check_result(tsp_pkg::res_t got, bit got_last);
    tsp_pkg::res_t e;
    bit el;
    checked++;
    if (exp_q.size() == 0) begin
      $display("%0t: unexpected result, got %h last %0b", $time, got, got_last);
      errors++;
      return;
    end
    e = exp_q.pop_front();
    el = exp_last_q.pop_front();
    if (got.kind !== e.kind)
      $display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
    if (got.value !== e.value)
      $display("%0t: value exp %h got %h", $time, e.value, got.value);
    if (got.option_code !== e.option_code)
      $display("%0t: option_code exp %h got %h", $time, e.option_code, got.option_code);
    if (got.win_width !== e.win_width)
      $display("%0t: win_width exp %h got %h", $time, e.win_width, got.win_width);
    if (got.win_height !== e.win_height)
      $display("%0t: win_height exp %h got %h", $time, e.win_height, got.win_height);
    if (got_last !== el)
      $display("%0t: last exp %0b got %0b", $time, el, got_last);
    if (got !== e || got_last !== el) errors++;
  endfunction
endclass

module telnet_stream_parser_tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tsp_in_if  in_ch();
  tsp_cfg_if cfg_ch();
  tsp_out_if out_ch();

  telnet_stream_parser dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in    (in_ch.source),
    .cfg   (cfg_ch.source),
    .out   (out_ch.sink)
  );

  tsp_scoreboard sb = new();
  int src_idle_pct;
  int snk_stall_pct;
  bit hold_off;
  int n_bytes;
  int n_cfg;
  longint cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d results outstanding", sb.exp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.kind, out_ch.value, out_ch.option_code,
                       out_ch.win_width, out_ch.win_height}, out_ch.last);
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // valid stays high after a transfer until the next byte or an idle cycle
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_byte(b);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_seq(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_opt();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'h01;
      2: return tsp_pkg::B_NAWS;
      3: return 8'h03;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_item();
    logic [7:0] s[$];
    int n;
    case ($urandom_range(9))
      0: s = '{tsp_pkg::B_IAC, 8'($urandom_range(tsp_pkg::B_WILL, tsp_pkg::B_DONT)),
               pick_opt()};
      1: begin
        s = '{tsp_pkg::B_IAC, tsp_pkg::B_SB, pick_opt()};
        n = $urandom_range(6);
        repeat (n) s.push_back(8'($urandom));
        if ($urandom_range(3) == 0) s.push_back(8'($urandom));
        s.push_back(tsp_pkg::B_IAC);
        s.push_back(tsp_pkg::B_SE);
      end
      2: s = '{tsp_pkg::B_CR, ($urandom_range(1) ? tsp_pkg::B_LF : 8'h00)};
      3: s = '{tsp_pkg::B_DEL};
      4: s = '{tsp_pkg::B_IAC, tsp_pkg::B_IAC};
      5: s = '{8'($urandom)};
      default: s = '{8'($urandom_range(8'h20, 8'h7E))};
    endcase
    send_seq(s);
  endtask

  task automatic random_phase(int idle, int stall, int items);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    repeat (items) random_item();
  endtask

  initial begin
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_off = 1'b0;
    n_bytes = 0;
    n_cfg = 0;
    cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: negotiation, escapes, line handling, subnegotiation
    send_seq('{tsp_pkg::B_IAC, tsp_pkg::B_DO, 8'h01});
    send_seq('{8'h41, 8'h7E, 8'h20, tsp_pkg::B_DEL, tsp_pkg::B_IAC, tsp_pkg::B_IAC});
    send_seq('{tsp_pkg::B_CR, tsp_pkg::B_LF, tsp_pkg::B_DEL, 8'h00, 8'h80});
    send_seq('{tsp_pkg::B_CR, 8'h41, tsp_pkg::B_SB, tsp_pkg::B_IAC, 8'hF1});
    send_seq('{tsp_pkg::B_IAC, tsp_pkg::B_WILL, 8'h05, tsp_pkg::B_IAC, tsp_pkg::B_WONT,
               8'h03, tsp_pkg::B_IAC, tsp_pkg::B_DONT, 8'h01});
    send_seq('{tsp_pkg::B_IAC, tsp_pkg::B_SB, tsp_pkg::B_NAWS, 8'h00, 8'h50,
               tsp_pkg::B_IAC, tsp_pkg::B_SE});
    send_seq('{tsp_pkg::B_IAC, tsp_pkg::B_SB, 8'h18, 8'hAA, tsp_pkg::B_IAC,
               tsp_pkg::B_IAC, tsp_pkg::B_IAC, 8'h01, tsp_pkg::B_IAC, tsp_pkg::B_SE});

    write_reg(tsp_pkg::REG_MASK, 8'h0);
    send_seq('{tsp_pkg::B_IAC, tsp_pkg::B_DO, 8'h01, tsp_pkg::B_IAC, tsp_pkg::B_DO,
               8'h00});
    write_reg(tsp_pkg::REG_CANON, 8'h0);
    send_seq('{8'h00, tsp_pkg::B_CR, tsp_pkg::B_DEL, 8'hFF});

    write_reg(tsp_pkg::REG_MASK, 8'hF);
    random_phase(0, 0, 10);
    write_reg(tsp_pkg::REG_CANON, 8'h1);
    random_phase(54, 0, 12);
    write_reg(tsp_pkg::REG_MASK, 8'h5);
    random_phase(0, 54, 12);

    // long receiver hold-off while bytes keep arriving
    src_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (30) send_seq('{8'h61});
    join
    drain();

    write_reg(tsp_pkg::REG_MASK, 8'hA);
    random_phase(16, 16, 12);
    write_reg(tsp_pkg::REG_CANON, 8'h0);
    random_phase(0, 0, 6);
    write_reg(tsp_pkg::REG_CANON, 8'h1);
    write_reg(tsp_pkg::REG_MASK, 8'hF);
    random_phase(54, 54, 10);

    drain();
    repeat (20) @(negedge clk_i);
    $display("%0d bytes sent, %0d results checked, %0d register writes",
             n_bytes, sb.checked, n_cfg);
    $display("covered negotiation, escapes, line edits, subnegotiation, idle and stall mixes");
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
